FILE: design/mrof_pkg.sv
// ----------------------------------------------------------------------------
// mrof_pkg
// Shared widths, register codes and inter-module structs for the
// median-relative outlier flagger.
// ----------------------------------------------------------------------------
package mrof_pkg;

  localparam int DEV_W       = 16;  // deviation, unsigned Q8.8
  localparam int CUT_W       = 20;  // cut value, (median * factor) >> 8
  localparam int FACTOR_W    = 12;  // cut multiplier, unsigned Q4.8
  localparam int CHAN_W      = 6;   // channel index on the result stream
  localparam int GRP_CNT_W   = 7;   // channel count of a group, covers 64
  localparam int GRP_IDX_W   = 6;   // channel slot of a group, covers 0..63
  localparam int BIT_W       = 4;   // bit position within a deviation
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD_W   = OUT_TDATA_W - CHAN_W - DEV_W;
  localparam int CFG_IDX_W   = 1;

  localparam logic [FACTOR_W-1:0] LOW_FACTOR_RST  = 12'd128;
  localparam logic [FACTOR_W-1:0] HIGH_FACTOR_RST = 12'd512;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_FACTOR  = 1'b0,
    REG_HIGH_FACTOR = 1'b1
  } cfg_reg_t;

  // one channel written into the group store
  typedef struct packed {
    logic                 en;
    logic                 buf_sel;
    logic [GRP_IDX_W-1:0] idx;
    logic                 flag;
    logic [DEV_W-1:0]     dev;
  } store_wr_t;

  // one closed group waiting for the back end
  typedef struct packed {
    logic                 buf_sel;
    logic [GRP_CNT_W-1:0] total;
    logic [GRP_CNT_W-1:0] active;
  } grp_desc_t;

  // cut multipliers
  typedef struct packed {
    logic [FACTOR_W-1:0] low;
    logic [FACTOR_W-1:0] high;
  } cut_cfg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_MEDIAN,
    BK_CUTS,
    BK_EMIT
  } back_state_t;

endpackage

FILE: design/mrof_front.sv
// ----------------------------------------------------------------------------
// mrof_front
// Accepts channel items, writes them into the group store and hands each
// closed group to the back end as a descriptor.
// ----------------------------------------------------------------------------
module mrof_front import mrof_pkg::*; #(
  parameter int MAX_CHANNELS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [DEV_W-1:0]      deviation,
  input  logic                  was_suppressed,
  input  logic                  last_channel,
  output store_wr_t             wr,
  output logic                  push,
  output grp_desc_t             push_desc,
  input  logic                  grp_done
);

  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] act;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] act_inc;
  logic             wbuf;
  logic [1:0]       pending;
  logic [1:0]       pending_next;
  logic             accept;
  logic             closing;

  // two store buffers: stall only while both hold closed groups
  assign s_tready = (pending != 2'd2);
  assign accept   = s_tvalid && s_tready;
  assign closing  = accept && (last_channel || (cnt == CNT_W'(MAX_CHANNELS - 1)));
  assign cnt_inc  = cnt + CNT_W'(1);
  assign act_inc  = act + CNT_W'(!was_suppressed);

  // store write for the accepted channel
  always_comb begin
    wr.en      = accept;
    wr.buf_sel = wbuf;
    wr.idx     = GRP_IDX_W'(cnt);
    wr.flag    = was_suppressed;
    wr.dev     = deviation;
  end

  // group descriptor on close
  assign push             = closing;
  assign push_desc.buf_sel = wbuf;
  assign push_desc.total   = GRP_CNT_W'(cnt_inc);
  assign push_desc.active  = GRP_CNT_W'(act_inc);

  // track closed groups not yet drained by the back end
  always_comb begin
    unique case ({closing, grp_done})
      2'b10:   pending_next = pending + 2'd1;
      2'b01:   pending_next = pending - 2'd1;
      default: pending_next = pending;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      act     <= '0;
      wbuf    <= 1'b0;
      pending <= '0;
    end else begin
      pending <= pending_next;
      if (accept) begin
        if (closing) begin
          cnt  <= '0;
          act  <= '0;
          wbuf <= ~wbuf;
        end else begin
          cnt <= cnt_inc;
          act <= act_inc;
        end
      end
    end
  end

endmodule

FILE: design/mrof_queue.sv
// ----------------------------------------------------------------------------
// mrof_queue
// Two-entry descriptor queue between the front and the back end.
// ----------------------------------------------------------------------------
module mrof_queue import mrof_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  grp_desc_t push_desc,
  input  logic      pop,
  output grp_desc_t pop_desc,
  output logic      not_empty
);

  grp_desc_t  entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign not_empty = (count != 2'd0);
  assign do_push   = push && (count != 2'd2);
  assign do_pop    = pop && not_empty;
  assign pop_desc  = entries[rptr];

  // hold descriptors
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_desc;
    end
  end

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/mrof_back.sv
// ----------------------------------------------------------------------------
// mrof_back
// Holds the double-buffered group store, finds the median of the active
// channels by a bitwise rank search, derives the cuts and emits one result
// per channel through an output register.
// ----------------------------------------------------------------------------
module mrof_back import mrof_pkg::*; #(
  parameter int MAX_CHANNELS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  store_wr_t         wr,
  input  logic              desc_valid,
  input  grp_desc_t         desc,
  output logic              desc_pop,
  input  cut_cfg_t          cuts_cfg,
  output logic              grp_done,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [CHAN_W-1:0] channel_index,
  output logic              suppressed_out,
  output logic [DEV_W-1:0]  group_median,
  output logic              last_result
);

  localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
  localparam int IDX_W  = $clog2(MAX_CHANNELS);
  localparam int ROWS   = (MAX_CHANNELS + 1) / 2;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ADDR_W = ROW_W + 1;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int ENT_W  = DEV_W + 1;
  localparam int CMP_W  = CNT_W + 1;

  // even and odd channel banks, each row holds one channel pair
  logic [ENT_W-1:0] mem_even [DEPTH];
  logic [ENT_W-1:0] mem_odd  [DEPTH];
  logic [ENT_W-1:0] rd_even;
  logic [ENT_W-1:0] rd_odd;
  logic [DEV_W-1:0] dev_even;
  logic [DEV_W-1:0] dev_odd;
  logic [ROW_W-1:0] wr_row;
  logic [ROW_W-1:0] rd_row;
  logic             rd_en;

  back_state_t      state, state_next;
  logic             cur_buf, cur_buf_next;
  logic [CNT_W-1:0] total, total_next;
  logic [CNT_W-1:0] rows, rows_next;
  logic [CNT_W-1:0] k1, k1_next;
  logic [CNT_W-1:0] k2, k2_next;
  logic [CNT_W-1:0] cnt1, cnt1_next;
  logic [CNT_W-1:0] cnt2, cnt2_next;
  logic [CNT_W-1:0] issue_row, issue_row_next;
  logic [BIT_W-1:0] bitpos, bitpos_next;
  logic             sdv, sdv_next;
  logic [ROW_W-1:0] srow, srow_next;
  logic [DEV_W-1:0] pre1, pre1_next;
  logic [DEV_W-1:0] pre2, pre2_next;
  logic [DEV_W-1:0] median, median_next;
  logic [CUT_W-1:0] locut, locut_next;
  logic [CUT_W-1:0] hicut, hicut_next;
  logic [CNT_W-1:0] emit_idx, emit_idx_next;
  logic             edv, edv_next;
  logic [IDX_W-1:0] eidx, eidx_next;
  logic             m_tvalid_next;
  logic [CHAN_W-1:0] out_idx_next;
  logic             out_sup_next;
  logic [DEV_W-1:0] out_med_next;
  logic             out_last_next;

  logic [DEV_W-1:0] himask;
  logic             in0, in1, act0, act1;
  logic             h10, h11, h20, h21;
  logic [1:0]       hits1, hits2;
  logic [CNT_W-1:0] act_cnt;
  logic             load_out;
  logic             issue;
  logic [ENT_W-1:0] sel_entry;
  logic [CUT_W-1:0] sel_dev;
  logic             eidx_last;

  // store write port
  assign wr_row = ROW_W'(wr.idx >> 1);

  always_ff @(posedge clk) begin
    if (wr.en && !wr.idx[0]) begin
      mem_even[{wr.buf_sel, wr_row}] <= {wr.flag, wr.dev};
    end
    if (wr.en && wr.idx[0]) begin
      mem_odd[{wr.buf_sel, wr_row}] <= {wr.flag, wr.dev};
    end
  end

  // registered read of one channel pair
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_even <= mem_even[{cur_buf, rd_row}];
      rd_odd  <= mem_odd[{cur_buf, rd_row}];
    end
  end

  assign dev_even = rd_even[DEV_W-1:0];
  assign dev_odd  = rd_odd[DEV_W-1:0];

  // rank search: count active channels that share the prefix and have a
  // zero at the current bit, for both middle ranks at once
  assign himask = ~(16'hFFFF >> (4'd15 - bitpos));
  assign in0    = CMP_W'({srow, 1'b0}) < CMP_W'(total);
  assign in1    = CMP_W'({srow, 1'b1}) < CMP_W'(total);
  assign act0   = in0 && !rd_even[DEV_W];
  assign act1   = in1 && !rd_odd[DEV_W];
  assign h10 = act0 && (((dev_even ^ pre1) & himask) == '0) && !dev_even[bitpos];
  assign h11 = act1 && (((dev_odd  ^ pre1) & himask) == '0) && !dev_odd[bitpos];
  assign h20 = act0 && (((dev_even ^ pre2) & himask) == '0) && !dev_even[bitpos];
  assign h21 = act1 && (((dev_odd  ^ pre2) & himask) == '0) && !dev_odd[bitpos];
  assign hits1 = {1'b0, h10} + {1'b0, h11};
  assign hits2 = {1'b0, h20} + {1'b0, h21};

  assign act_cnt = CNT_W'(desc.active);

  // result of the channel whose pair is in the read register
  assign sel_entry = eidx[0] ? rd_odd : rd_even;
  assign sel_dev   = CUT_W'(sel_entry[DEV_W-1:0]);
  assign eidx_last = (CNT_W'(eidx) + CNT_W'(1)) == total;
  assign load_out  = edv && (!m_tvalid || m_tready);
  assign issue     = (state == BK_EMIT) && (emit_idx < total) && (!edv || load_out);

  always_comb begin
    state_next     = state;
    cur_buf_next   = cur_buf;
    total_next     = total;
    rows_next      = rows;
    k1_next        = k1;
    k2_next        = k2;
    cnt1_next      = cnt1;
    cnt2_next      = cnt2;
    issue_row_next = issue_row;
    bitpos_next    = bitpos;
    sdv_next       = sdv;
    srow_next      = srow;
    pre1_next      = pre1;
    pre2_next      = pre2;
    median_next    = median;
    locut_next     = locut;
    hicut_next     = hicut;
    emit_idx_next  = emit_idx;
    edv_next       = edv;
    eidx_next      = eidx;
    rd_en          = 1'b0;
    rd_row         = '0;
    desc_pop       = 1'b0;
    grp_done       = 1'b0;
    m_tvalid_next  = m_tvalid;
    out_idx_next   = channel_index;
    out_sup_next   = suppressed_out;
    out_med_next   = group_median;
    out_last_next  = last_result;

    // output register: load a finished result, drop it once taken
    if (load_out) begin
      m_tvalid_next = 1'b1;
      out_idx_next  = CHAN_W'(eidx);
      out_sup_next  = sel_entry[DEV_W] || (sel_dev < locut) || (sel_dev > hicut);
      out_med_next  = median;
      out_last_next = eidx_last;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end

    unique case (state)
      BK_IDLE: begin
        // take the next closed group and set up both middle ranks
        if (desc_valid) begin
          desc_pop       = 1'b1;
          cur_buf_next   = desc.buf_sel;
          total_next     = CNT_W'(desc.total);
          rows_next      = (CNT_W'(desc.total) + CNT_W'(1)) >> 1;
          k2_next        = act_cnt >> 1;
          k1_next        = (!act_cnt[0] && (act_cnt != '0)) ?
                           (act_cnt >> 1) - CNT_W'(1) : (act_cnt >> 1);
          pre1_next      = '0;
          pre2_next      = '0;
          cnt1_next      = '0;
          cnt2_next      = '0;
          issue_row_next = '0;
          sdv_next       = 1'b0;
          bitpos_next    = BIT_W'(DEV_W - 1);
          state_next     = (act_cnt == '0) ? BK_MEDIAN : BK_SCAN;
        end
      end

      BK_SCAN: begin
        // accumulate counts of the pair read last cycle
        if (sdv) begin
          cnt1_next = cnt1 + CNT_W'(hits1);
          cnt2_next = cnt2 + CNT_W'(hits2);
        end
        // walk the rows of the group
        if (issue_row < rows) begin
          rd_en          = 1'b1;
          rd_row         = ROW_W'(issue_row);
          srow_next      = ROW_W'(issue_row);
          issue_row_next = issue_row + CNT_W'(1);
          sdv_next       = 1'b1;
        end else begin
          sdv_next = 1'b0;
        end
        // pass done: settle this bit of both ranks
        if ((issue_row == rows) && !sdv) begin
          if (k1 >= cnt1) begin
            pre1_next[bitpos] = 1'b1;
            k1_next           = k1 - cnt1;
          end
          if (k2 >= cnt2) begin
            pre2_next[bitpos] = 1'b1;
            k2_next           = k2 - cnt2;
          end
          cnt1_next      = '0;
          cnt2_next      = '0;
          issue_row_next = '0;
          if (bitpos == '0) begin
            state_next = BK_MEDIAN;
          end else begin
            bitpos_next = bitpos - BIT_W'(1);
          end
        end
      end

      BK_MEDIAN: begin
        median_next = DEV_W'(((DEV_W + 1)'(pre1) + (DEV_W + 1)'(pre2)) >> 1);
        state_next  = BK_CUTS;
      end

      BK_CUTS: begin
        locut_next    = CUT_W'((28'(median) * 28'(cuts_cfg.low)) >> 8);
        hicut_next    = CUT_W'((28'(median) * 28'(cuts_cfg.high)) >> 8);
        emit_idx_next = '0;
        edv_next      = 1'b0;
        state_next    = BK_EMIT;
      end

      BK_EMIT: begin
        // read channels in order, one per cycle while the output drains
        if (issue) begin
          rd_en         = 1'b1;
          rd_row        = ROW_W'(emit_idx >> 1);
          eidx_next     = IDX_W'(emit_idx);
          emit_idx_next = emit_idx + CNT_W'(1);
        end
        edv_next = issue ? 1'b1 : (load_out ? 1'b0 : edv);
        if (load_out && eidx_last) begin
          grp_done   = 1'b1;
          state_next = BK_IDLE;
        end
      end

      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      sdv      <= 1'b0;
      edv      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      sdv      <= sdv_next;
      edv      <= edv_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cur_buf        <= cur_buf_next;
    total          <= total_next;
    rows           <= rows_next;
    k1             <= k1_next;
    k2             <= k2_next;
    cnt1           <= cnt1_next;
    cnt2           <= cnt2_next;
    issue_row      <= issue_row_next;
    bitpos         <= bitpos_next;
    srow           <= srow_next;
    pre1           <= pre1_next;
    pre2           <= pre2_next;
    median         <= median_next;
    locut          <= locut_next;
    hicut          <= hicut_next;
    emit_idx       <= emit_idx_next;
    eidx           <= eidx_next;
    channel_index  <= out_idx_next;
    suppressed_out <= out_sup_next;
    group_median   <= out_med_next;
    last_result    <= out_last_next;
  end

endmodule

FILE: design/median_relative_outlier_flagger_core.sv
// ----------------------------------------------------------------------------
// median_relative_outlier_flagger_core
// Flags outlier channels of a group against cuts scaled from the median
// deviation of the channels not yet suppressed.
// ----------------------------------------------------------------------------
// Channels stream in at one transfer per cycle; a group closes on tlast or
// when MAX_CHANNELS channels are held, and then yields one result per channel
// in arrival order. The store is double buffered, so the next group loads
// while the previous one is worked on; input stalls only while two closed
// groups are waiting. For a group with at least one active channel, the back
// end takes the group, runs 16 rank-search passes (one channel pair read
// from the store per cycle, one pass per deviation bit), forms the median
// and the cuts, then emits the results; result stalls lengthen the emit
// phase. A group with no active channel skips the search. The store needs
// no clearing after reset.
module median_relative_outlier_flagger_core import mrof_pkg::*; #(
  parameter int MAX_CHANNELS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] deviation
  input  logic                   s_tuser,   // [0] was_suppressed
  input  logic                   s_tlast,   // last_channel
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [5:0] channel_index, [21:6] group_median
  output logic                   m_tuser,   // [0] suppressed_out
  output logic                   m_tlast,   // last_result
  input  logic                   cfg_wen,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [FACTOR_W-1:0]    cfg_wdata
);

  store_wr_t         wr;
  logic              push;
  grp_desc_t         push_desc;
  logic              pop;
  grp_desc_t         pop_desc;
  logic              not_empty;
  logic              grp_done;
  cut_cfg_t          cuts_cfg;
  logic [CHAN_W-1:0] channel_index;
  logic [DEV_W-1:0]  group_median;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cuts_cfg.low  <= LOW_FACTOR_RST;
      cuts_cfg.high <= HIGH_FACTOR_RST;
    end else if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LOW_FACTOR:  cuts_cfg.low  <= cfg_wdata;
        REG_HIGH_FACTOR: cuts_cfg.high <= cfg_wdata;
        default:         cuts_cfg      <= cuts_cfg;
      endcase
    end
  end

  mrof_front #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .deviation      (s_tdata[DEV_W-1:0]),
    .was_suppressed (s_tuser),
    .last_channel   (s_tlast),
    .wr             (wr),
    .push           (push),
    .push_desc      (push_desc),
    .grp_done       (grp_done)
  );

  mrof_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .pop_desc  (pop_desc),
    .not_empty (not_empty)
  );

  mrof_back #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .wr             (wr),
    .desc_valid     (not_empty),
    .desc           (pop_desc),
    .desc_pop       (pop),
    .cuts_cfg       (cuts_cfg),
    .grp_done       (grp_done),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .channel_index  (channel_index),
    .suppressed_out (m_tuser),
    .group_median   (group_median),
    .last_result    (m_tlast)
  );

  // pack the result transfer
  assign m_tdata = {{OUT_PAD_W{1'b0}}, group_median, channel_index};

endmodule

FILE: design/mrof_checker.sv
// ----------------------------------------------------------------------------
// mrof_checker
// Port-level checks on the result stream of the outlier flagger.
// ----------------------------------------------------------------------------
module mrof_checker import mrof_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic                   m_tuser,
  input logic                   m_tlast
);

  logic              in_xfer;
  logic              out_xfer;
  logic [CHAN_W-1:0] exp_idx;
  logic [DEV_W-1:0]  prev_med;
  logic              in_group;
  logic [8:0]        backlog;

  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;

  // track position within the result group and items owed
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_idx  <= '0;
      in_group <= 1'b0;
      backlog  <= '0;
    end else begin
      if (out_xfer) begin
        exp_idx  <= m_tlast ? '0 : m_tdata[CHAN_W-1:0] + CHAN_W'(1);
        in_group <= !m_tlast;
      end
      backlog <= backlog + 9'(in_xfer) - 9'(out_xfer);
    end
  end

  always_ff @(posedge clk) begin
    if (out_xfer) begin
      prev_med <= m_tdata[CHAN_W +: DEV_W];
    end
  end

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  a_index_order: assert property (@(posedge clk) disable iff (rst)
    out_xfer |-> m_tdata[CHAN_W-1:0] == exp_idx)
    else $error("channel index out of order");

  a_median_steady: assert property (@(posedge clk) disable iff (rst)
    out_xfer && in_group |-> m_tdata[CHAN_W +: DEV_W] == prev_med)
    else $error("median changed within a group");

  a_no_extra_result: assert property (@(posedge clk) disable iff (rst)
    out_xfer |-> backlog != '0)
    else $error("more results than accepted channels");

endmodule

bind median_relative_outlier_flagger_core mrof_checker u_mrof_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives channel groups into the median-relative outlier flagger and checks
// every result against typed-in values or a built-in predictor of median, cuts and flags.
// ----------------------------------------------------------------------------
// A short table of directed channels runs first. Its single-channel groups
// carry their expected result typed in; all other rows come from the
// predictor. Random groups follow under several cut settings and idle mixes.
// ----------------------------------------------------------------------------
module testbench;
  import mrof_pkg::*;

  localparam int GROUP_MAX   = 64;
  localparam int STALL_LIMIT = 5000;

  // one expected or observed result
  typedef struct {
    logic [CHAN_W-1:0] idx;
    logic              sup;
    logic [DEV_W-1:0]  median;
    logic              last;
  } flag_result_t;

  // one directed channel, with an optional typed-in result
  typedef struct {
    logic [DEV_W-1:0] dev;
    logic             sup;
    logic             last;
    bit               typed;
    logic             t_sup;
    logic [DEV_W-1:0] t_median;
  } chan_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;
  logic                   cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [FACTOR_W-1:0]    cfg_wdata = '0;

  int send_idle_pct = 33;
  int recv_idle_pct = 55;
  int errors = 0;
  int idle_cycles = 0;

  // predictor state
  logic [FACTOR_W-1:0] low_cut_factor  = LOW_FACTOR_RST;
  logic [FACTOR_W-1:0] high_cut_factor = HIGH_FACTOR_RST;
  logic [DEV_W-1:0]    group_dev[$];
  logic                group_flag[$];
  flag_result_t        expected_flags[$];
  chan_row_t           directed_rows[$];

  median_relative_outlier_flagger_core #(
    .MAX_CHANNELS(GROUP_MAX)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // 20-unit clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // check each result transfer against the oldest expectation
  always @(posedge clk) begin
    flag_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.idx    = m_tdata[CHAN_W-1:0];
      got.median = m_tdata[CHAN_W +: DEV_W];
      got.sup    = m_tuser;
      got.last   = m_tlast;
      if (expected_flags.size() == 0) begin
        $display("%0t: unexpected result idx=%0d sup=%0d median=%h last=%0d",
                 $time, got.idx, got.sup, got.median, got.last);
        errors++;
      end else begin
        want = expected_flags.pop_front();
        if (got.idx !== want.idx) begin
          $display("%0t: channel_index expected %0d actual %0d", $time, want.idx, got.idx);
          errors++;
        end
        if (got.sup !== want.sup) begin
          $display("%0t: suppressed_out (idx %0d) expected %0d actual %0d",
                   $time, want.idx, want.sup, got.sup);
          errors++;
        end
        if (got.median !== want.median) begin
          $display("%0t: group_median (idx %0d) expected %h actual %h",
                   $time, want.idx, want.median, got.median);
          errors++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last_result (idx %0d) expected %0d actual %0d",
                   $time, want.idx, want.last, got.last);
          errors++;
        end
      end
    end
  end

  // end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // median of the unsuppressed channels of the open group, truncated mean if even
  function automatic logic [DEV_W-1:0] active_median();
    logic [DEV_W-1:0] vals[GROUP_MAX];
    logic [DEV_W-1:0] v;
    int m;
    int j;
    m = 0;
    for (int i = 0; i < group_dev.size(); i++) begin
      if (!group_flag[i]) begin
        v = group_dev[i];
        j = m;
        while (j > 0 && vals[j-1] > v) begin
          vals[j] = vals[j-1];
          j--;
        end
        vals[j] = v;
        m++;
      end
    end
    if (m == 0) return '0;
    if (m % 2 == 1) return vals[m/2];
    return DEV_W'(({1'b0, vals[m/2-1]} + {1'b0, vals[m/2]}) >> 1);
  endfunction

  // add one accepted channel; on group close, queue its results if asked
  task automatic predict_channel(input logic [DEV_W-1:0] dev, input logic sup,
                                 input logic last, input bit record);
    logic [DEV_W-1:0] med;
    logic [CUT_W-1:0] lo_cut, hi_cut;
    flag_result_t r;
    int n;
    group_dev.push_back(dev);
    group_flag.push_back(sup);
    n = group_dev.size();
    if (last || n == GROUP_MAX) begin
      med    = active_median();
      lo_cut = CUT_W'((32'(med) * 32'(low_cut_factor)) >> 8);
      hi_cut = CUT_W'((32'(med) * 32'(high_cut_factor)) >> 8);
      for (int i = 0; i < n; i++) begin
        r.idx    = CHAN_W'(i);
        r.sup    = group_flag[i] || (CUT_W'(group_dev[i]) < lo_cut) ||
                   (CUT_W'(group_dev[i]) > hi_cut);
        r.median = med;
        r.last   = (i == n - 1);
        if (record) expected_flags.push_back(r);
      end
      group_dev.delete();
      group_flag.delete();
    end
  endtask

  // present one channel and hold it until the transfer
  task automatic send_channel(input logic [DEV_W-1:0] dev, input logic sup,
                              input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= dev;
    s_tuser  <= sup;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic add_row(input logic [DEV_W-1:0] dev, input logic sup, input logic last,
                         input bit typed, input logic t_sup, input logic [DEV_W-1:0] t_med);
    chan_row_t row;
    row.dev = dev;
    row.sup = sup;
    row.last = last;
    row.typed = typed;
    row.t_sup = t_sup;
    row.t_median = t_med;
    directed_rows.push_back(row);
  endtask

  // drop valid and hold until every expected result is out, then let the block settle
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_flags.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // write both cut multipliers while idle
  task automatic apply_cuts(input logic [FACTOR_W-1:0] lo, input logic [FACTOR_W-1:0] hi);
    cfg_wen   <= 1'b1;
    cfg_index <= REG_LOW_FACTOR;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= REG_HIGH_FACTOR;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_wen <= 1'b0;
    low_cut_factor  = lo;
    high_cut_factor = hi;
  endtask

  // one group of random channels clustered around a base, with some outliers
  task automatic send_random_group(input int n, input bit mark_last);
    logic [DEV_W-1:0] base, dev;
    logic sup, last;
    bit all_sup;
    base    = DEV_W'($urandom_range(0, 65535) >> $urandom_range(0, 8));
    all_sup = ($urandom_range(11) == 0);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: dev = DEV_W'($urandom);
        1: dev = '0;
        2: dev = '1;
        3: dev = base << 2;
        4: dev = base >> 2;
        default: dev = base + DEV_W'($urandom_range(0, base / 4 + 1)) - DEV_W'(base / 8);
      endcase
      sup  = all_sup || ($urandom_range(4) == 0);
      last = mark_last && (i == n - 1);
      send_channel(dev, sup, last);
      predict_channel(dev, sup, last, 1'b1);
    end
  endtask

  initial begin
    flag_result_t r;
    int sent;
    int n;

    // directed table: typed rows are single-channel groups under reset cuts
    add_row(16'h0000, 1'b0, 1'b1, 1, 1'b0, 16'h0000);
    add_row(16'hFFFF, 1'b0, 1'b1, 1, 1'b0, 16'hFFFF);
    add_row(16'h1234, 1'b1, 1'b1, 1, 1'b1, 16'h0000);
    add_row(16'h0000, 1'b1, 1'b1, 1, 1'b1, 16'h0000);
    add_row(16'h8000, 1'b0, 1'b1, 1, 1'b0, 16'h8000);
    // even count, exact mean
    add_row(16'h0100, 1'b0, 1'b0, 0, 1'b0, 16'h0000);
    add_row(16'h0300, 1'b0, 1'b1, 0, 1'b0, 16'h0000);
    // even count, truncated mean
    add_row(16'h0001, 1'b0, 1'b0, 0, 1'b0, 16'h0000);
    add_row(16'h0002, 1'b0, 1'b1, 0, 1'b0, 16'h0000);
    // below and above the cuts, one suppressed
    add_row(16'h0100, 1'b0, 1'b0, 0, 1'b0, 16'h0000);
    add_row(16'h1000, 1'b0, 1'b0, 0, 1'b0, 16'h0000);
    add_row(16'h0010, 1'b0, 1'b0, 0, 1'b0, 16'h0000);
    add_row(16'h0110, 1'b1, 1'b0, 0, 1'b0, 16'h0000);
    add_row(16'h0120, 1'b0, 1'b1, 0, 1'b0, 16'h0000);
    // no unsuppressed channel
    add_row(16'h0005, 1'b1, 1'b0, 0, 1'b0, 16'h0000);
    add_row(16'h0000, 1'b1, 1'b0, 0, 1'b0, 16'h0000);
    add_row(16'h0007, 1'b1, 1'b1, 0, 1'b0, 16'h0000);
    // extreme deviations mixed
    add_row(16'hFFFF, 1'b0, 1'b0, 0, 1'b0, 16'h0000);
    add_row(16'hFFFE, 1'b0, 1'b0, 0, 1'b0, 16'h0000);
    add_row(16'h0000, 1'b0, 1'b1, 0, 1'b0, 16'h0000);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    foreach (directed_rows[i]) begin
      send_channel(directed_rows[i].dev, directed_rows[i].sup, directed_rows[i].last);
      predict_channel(directed_rows[i].dev, directed_rows[i].sup, directed_rows[i].last,
                      !directed_rows[i].typed);
      if (directed_rows[i].typed) begin
        r.idx    = '0;
        r.sup    = directed_rows[i].t_sup;
        r.median = directed_rows[i].t_median;
        r.last   = 1'b1;
        expected_flags.push_back(r);
      end
    end

    // random part: three idle mixes, two cut settings each
    for (int phase = 0; phase < 6; phase++) begin
      drain_results();
      case (phase)
        0: apply_cuts(12'd0, 12'd4095);
        1: apply_cuts(12'd4095, 12'd0);
        2: begin
          send_idle_pct = 55;
          recv_idle_pct = 33;
          apply_cuts(12'd256, 12'd256);
        end
        3: apply_cuts(FACTOR_W'($urandom_range(0, 512)), FACTOR_W'($urandom_range(256, 4095)));
        4: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          apply_cuts(LOW_FACTOR_RST, HIGH_FACTOR_RST);
        end
        default: apply_cuts(FACTOR_W'($urandom), FACTOR_W'($urandom));
      endcase
      // full store closes the group without a last mark
      if (phase == 0) send_random_group(GROUP_MAX, 1'b0);
      sent = 0;
      while (sent < 3) begin
        n = ($urandom_range(11) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        send_random_group(n, 1'b1);
        sent += n;
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: median_relative_outlier_flagger_core.f
design/mrof_pkg.sv
design/mrof_front.sv
design/mrof_queue.sv
design/mrof_back.sv
design/median_relative_outlier_flagger_core.sv
design/mrof_checker.sv
tb/testbench.sv
